/* src/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants for the coin peak classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

    localparam int MAX_COINS      = 4;
    localparam int SAMPLE_W       = 10;
    localparam int VALUE_W        = 16;
    localparam int ENTRY_W        = SAMPLE_W + VALUE_W;
    localparam int TOTAL_W        = 32;
    localparam int TALLY_W        = 16;
    localparam int INDEX_W        = 2;
    localparam int REG_IDX_W      = 3;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 56;
    localparam int OUT_TUSER_W    = 2;

    localparam logic [SAMPLE_W:0] PRESENT_MARGIN = 11'd8;
    localparam logic [SAMPLE_W-1:0] RETURN_MARGIN = 10'd2;
    localparam logic [SAMPLE_W-1:0] TOL_RESET = 10'd10;

    // register indexes: coin entries occupy 0 .. MAX_COINS-1
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_BASELINE = 2'd1,
        EV_ACCEPT   = 2'd2,
        EV_REJECT   = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [MAX_COINS-1:0][ENTRY_W-1:0] entry;
        logic [SAMPLE_W-1:0]               tolerance;
    } cpc_cfg_t;

    typedef struct packed {
        event_kind_t         kind;
        logic [INDEX_W-1:0]  coin_index;
        logic [TOTAL_W-1:0]  running_total;
        logic [TALLY_W-1:0]  coin_tally;
    } cpc_result_t;

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

/* src/cpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cpc_cfg_regs
// Coin signature table and match tolerance, written through the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_cfg_regs #(
    parameter int NUM_COINS = 4
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wen,
    input  wire  [cpc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire  [cpc_pkg::ENTRY_W-1:0]        cfg_data,
    output cpc_pkg::cpc_cfg_t                  cfg
);
    import cpc_pkg::*;

    logic [NUM_COINS-1:0][ENTRY_W-1:0] entry_reg;
    logic [SAMPLE_W-1:0]               tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tol_reg   <= TOL_RESET;
        end
        else if (cfg_wen)
        begin
            for (int i = 0; i < NUM_COINS; i++)
            begin
                if (cfg_index == REG_IDX_W'(i))
                    entry_reg[i] <= cfg_data;
            end
            if (cfg_index == REG_TOLERANCE)
                tol_reg <= cfg_data[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        cfg           = '0;
        cfg.tolerance = tol_reg;
        for (int i = 0; i < NUM_COINS; i++)
            cfg.entry[i] = entry_reg[i];
    end

endmodule

`default_nettype wire

/* src/cpc_tracker.sv */
// ----------------------------------------------------------------------------
// cpc_tracker
// Baseline / peak tracking, coin detection, signature match and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_tracker #(
    parameter int NUM_COINS = 4
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              step,
    input  wire  [cpc_pkg::SAMPLE_W-1:0]     sample,
    input  cpc_pkg::cpc_cfg_t                cfg,
    output cpc_pkg::cpc_result_t             result
);
    import cpc_pkg::*;

    logic [SAMPLE_W-1:0]               baseline_reg, baseline_next;
    logic [SAMPLE_W-1:0]               peak_reg, peak_next;
    logic                              present_reg, present_next;
    logic                              need_base_reg, need_base_next;
    logic [TOTAL_W-1:0]                total_reg, total_next;
    logic [NUM_COINS-1:0][TALLY_W-1:0] count_reg, count_next;

    logic [SAMPLE_W-1:0]  peak_cand;
    logic                 present_cand;
    logic                 finish;
    logic [NUM_COINS-1:0] first_hit;
    logic                 found;
    logic [VALUE_W-1:0]   hit_value;
    logic [TOTAL_W:0]     sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            peak_reg      <= '0;
            present_reg   <= 1'b0;
            need_base_reg <= 1'b1;
            total_reg     <= '0;
            count_reg     <= '0;
        end
        else if (step)
        begin
            baseline_reg  <= baseline_next;
            peak_reg      <= peak_next;
            present_reg   <= present_next;
            need_base_reg <= need_base_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
        end
    end

    always_comb
    begin
        peak_cand    = (sample > peak_reg) ? sample : peak_reg;
        present_cand = present_reg | ({1'b0, sample} > ({1'b0, baseline_reg} + PRESENT_MARGIN));
        finish       = !need_base_reg && present_cand &&
                       (abs_diff(sample, baseline_reg) < RETURN_MARGIN);

        // parallel signature compares, lowest index wins
        found     = 1'b0;
        first_hit = '0;
        hit_value = '0;
        for (int i = 0; i < NUM_COINS; i++)
        begin
            if (!found && (abs_diff(peak_cand, cfg.entry[i][SAMPLE_W-1:0]) < cfg.tolerance))
            begin
                found        = 1'b1;
                first_hit[i] = 1'b1;
                hit_value    = cfg.entry[i][ENTRY_W-1:SAMPLE_W];
            end
        end

        sum = {1'b0, total_reg} + (TOTAL_W+1)'(hit_value);

        baseline_next  = baseline_reg;
        peak_next      = peak_cand;
        present_next   = present_cand;
        need_base_next = need_base_reg;
        total_next     = total_reg;
        count_next     = count_reg;

        result               = '0;
        result.kind          = EV_NONE;
        result.running_total = total_reg;

        if (need_base_reg)
        begin
            baseline_next  = sample;
            peak_next      = sample;
            present_next   = 1'b0;
            need_base_next = 1'b0;
            result.kind    = EV_BASELINE;
        end
        else if (finish)
        begin
            present_next   = 1'b0;
            need_base_next = 1'b1;
            if (found)
            begin
                total_next  = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                result.kind = EV_ACCEPT;
                for (int i = 0; i < NUM_COINS; i++)
                begin
                    if (first_hit[i])
                    begin
                        if (count_reg[i] != {TALLY_W{1'b1}})
                            count_next[i] = count_reg[i] + 1'b1;
                        result.coin_index = INDEX_W'(i);
                        result.coin_tally = count_next[i];
                    end
                end
            end
            else
            begin
                result.kind = EV_REJECT;
            end
        end

        result.running_total = total_next;
    end

endmodule

`default_nettype wire

/* src/coin_peak_classifier_core.sv */
// ----------------------------------------------------------------------------
// coin_peak_classifier_core
// IR coin acceptor: classifies coins by the peak of the sensor reading.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one 10-bit converter sample per request. every accepted
//   sample gives exactly one result on m_axis: the event kind in tuser
//   (none, baseline captured, coin accepted, coin rejected) and the coin
//   index, running total and per-coin tally in tdata.
//   the first sample after reset, and the first after each finished coin,
//   is taken as the new idle baseline.
//   the result is registered: one input register, then the tracker logic
//   feeding the result register. one sample per cycle is sustained while
//   m_axis does not stall; the tracker state updates once per request and
//   is the only feedback loop.
//   when m_axis stalls the result register holds and s_axis tready stays
//   high until the input register is also full.
//   reset clears the baseline, peak, total and per-coin counts, sets the
//   coin entries to zero and the tolerance to 10.
//   config writes (cfg_wen, cfg_index, cfg_data) take effect at the next
//   edge and are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module coin_peak_classifier_core #(
    parameter int NUM_COINS = 4
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // sample [9:0]
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [cpc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // coin_index [1:0], running_total [33:2], coin_tally [49:34]
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [cpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // event_kind [1:0]
    output logic [cpc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  wire                                 cfg_wen,
    input  wire  [cpc_pkg::REG_IDX_W-1:0]       cfg_index,
    input  wire  [cpc_pkg::ENTRY_W-1:0]         cfg_data
);
    import cpc_pkg::*;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg;
    cpc_result_t         result_reg;
    cpc_result_t         result;
    cpc_cfg_t            cfg;
    logic                advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
        if (advance)
            result_reg <= result;
    end

    cpc_cfg_regs #(
        .NUM_COINS (NUM_COINS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpc_tracker #(
        .NUM_COINS (NUM_COINS)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (sample_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.kind;
    assign m_axis_tdata  = {6'd0, result_reg.coin_tally, result_reg.running_total,
                            result_reg.coin_index};

endmodule

`default_nettype wire

/* src/cpc_checker.sv */
// ----------------------------------------------------------------------------
// cpc_checker
// Port-level checks on the coin peak classifier result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 m_axis_tvalid,
    input  wire                                 m_axis_tready,
    input  wire  [cpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire  [cpc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
    import cpc_pkg::*;

    logic                out_fire;
    logic [TOTAL_W-1:0]  total;
    logic [TOTAL_W-1:0]  last_total_reg;
    logic                coin_done_reg;

    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign total    = m_axis_tdata[TOTAL_W+INDEX_W-1:INDEX_W];

    // tracks the previous delivered result; after reset a baseline is due
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
            coin_done_reg  <= 1'b1;
        end
        else if (out_fire)
        begin
            last_total_reg <= total;
            coin_done_reg  <= (m_axis_tuser == EV_ACCEPT) || (m_axis_tuser == EV_REJECT);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> total >= last_total_reg)
        else $error("running total decreased");

    a_baseline_after_coin: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && coin_done_reg |-> m_axis_tuser == EV_BASELINE)
        else $error("no baseline capture after a finished coin");

    a_accept_tally: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == EV_ACCEPT
        |-> m_axis_tdata[OUT_TDATA_W-7:TOTAL_W+INDEX_W] != '0)
        else $error("accepted coin with zero tally");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != EV_ACCEPT
        |-> m_axis_tdata[INDEX_W-1:0] == '0
        && m_axis_tdata[OUT_TDATA_W-7:TOTAL_W+INDEX_W] == '0)
        else $error("index or tally set without an accepted coin");

endmodule

bind coin_peak_classifier_core cpc_checker u_cpc_checker (.*);

`default_nettype wire
